// File: rtl/eacr_pkg.sv
// Package: shared types, register indexes, status codes and header constants.
`default_nettype none
package eacr_pkg;

  // Result status codes, in order of check priority after ok
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_STALE_EP   = 3'd2,
    ST_WRONG_SRC  = 3'd3,
    ST_WRONG_DST  = 3'd4,
    ST_STALE_GEN  = 3'd5,
    ST_AUTH_FAIL  = 3'd6,
    ST_REPLAY     = 3'd7
  } status_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOADED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_EPOCH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_SOURCE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_SOURCE_GEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_DEST       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_DEST_GEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_LIMIT     = 3'd6;

  // Header word 0 constants
  localparam logic [31:0] HDR_MAGIC   = 32'h4D50_4531;
  localparam logic [7:0]  HDR_VERSION = 8'd2;

  // Receiver context held in the configuration registers
  typedef struct packed {
    logic        key_loaded;
    logic [31:0] expected_epoch;
    logic [63:0] expected_source;
    logic [31:0] expected_source_gen;
    logic [63:0] expected_dest;
    logic [31:0] expected_dest_gen;
    logic [7:0]  payload_type_limit;
  } cfg_t;

  // One parsed envelope header with its tag verdict
  typedef struct packed {
    logic [63:0] header_word0;
    logic [31:0] epoch;
    logic [63:0] source_id;
    logic [31:0] source_gen;
    logic [63:0] dest_id;
    logic [31:0] dest_gen;
    logic [63:0] via_id;
    logic [63:0] sequence_req;
    logic        auth_ok;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/eacr_check.sv
// Header and context checks giving the status before the replay window.
`default_nettype none
module eacr_check (
  input  eacr_pkg::cfg_t    cfg,
  input  eacr_pkg::item_t   item,
  input  logic              win_ok,
  output eacr_pkg::status_t chk_status
);
  import eacr_pkg::*;

  logic [7:0] flag;
  logic [7:0] ptype;
  logic       ctx_bad;
  logic       hdr_bad;
  logic       ids_bad;
  logic       via_bad;
  logic       is_invalid;

  assign flag  = item.header_word0[23:16];
  assign ptype = item.header_word0[15:8];

  // Receiver context must be complete and self-consistent
  assign ctx_bad = !cfg.key_loaded || (cfg.expected_epoch == '0) ||
                   (cfg.expected_source == '0) || (cfg.expected_source_gen == '0) ||
                   (cfg.expected_dest == '0) || (cfg.expected_dest_gen == '0) ||
                   (cfg.expected_source == cfg.expected_dest);

  // Fixed header fields
  assign hdr_bad = (item.header_word0[63:32] != HDR_MAGIC) ||
                   (item.header_word0[31:24] != HDR_VERSION) ||
                   (flag > 8'd1) || (ptype > cfg.payload_type_limit) ||
                   (item.header_word0[7:0] != 8'd0);

  // Identity fields must be nonzero and distinct
  assign ids_bad = (item.epoch == '0) || (item.source_id == '0) ||
                   (item.source_gen == '0) || (item.dest_id == '0) ||
                   (item.dest_gen == '0) || (item.source_id == item.dest_id) ||
                   (item.sequence_req == '0);

  // Relay id must not clash and must agree with the relay flag
  assign via_bad = ((item.via_id != '0) &&
                    ((item.via_id == item.source_id) || (item.via_id == item.dest_id))) ||
                   ((flag == 8'd0) != (item.via_id == '0));

  assign is_invalid = ctx_bad || !win_ok || hdr_bad || ids_bad || via_bad;

  // Priority encode the verdict
  always_comb begin
    if (is_invalid) begin
      chk_status = ST_INVALID;
    end else if (item.epoch != cfg.expected_epoch) begin
      chk_status = ST_STALE_EP;
    end else if (item.source_id != cfg.expected_source) begin
      chk_status = ST_WRONG_SRC;
    end else if (item.dest_id != cfg.expected_dest) begin
      chk_status = ST_WRONG_DST;
    end else if ((item.source_gen != cfg.expected_source_gen) ||
                 (item.dest_gen != cfg.expected_dest_gen)) begin
      chk_status = ST_STALE_GEN;
    end else if (!item.auth_ok) begin
      chk_status = ST_AUTH_FAIL;
    end else begin
      chk_status = ST_OK;
    end
  end

endmodule
`default_nettype wire

// File: rtl/eacr_window.sv
// Sliding anti-replay window: newest sequence and seen mask.
`default_nettype none
module eacr_window #(
  parameter int unsigned WINDOW_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [63:0] seq,
  output logic        replay,
  output logic        state_ok
);
  localparam int unsigned SW   = $clog2(WINDOW_SIZE);
  localparam logic [63:0] WLEN = 64'(WINDOW_SIZE);
  localparam logic [WINDOW_SIZE-1:0] ONE = {{(WINDOW_SIZE-1){1'b0}}, 1'b1};

  logic                   started_r;
  logic                   started_nxt;
  logic [63:0]            newest_r;
  logic [63:0]            newest_nxt;
  logic [WINDOW_SIZE-1:0] seen_r;
  logic [WINDOW_SIZE-1:0] seen_nxt;

  logic        ahead;
  logic [63:0] diff_up;
  logic [63:0] diff_dn;
  logic        jump;
  logic        too_old;
  logic        seen_bit;
  logic        accept;

  assign ahead    = seq > newest_r;
  assign diff_up  = seq - newest_r;
  assign diff_dn  = newest_r - seq;
  assign jump     = diff_up >= WLEN;
  assign too_old  = diff_dn >= WLEN;
  assign seen_bit = seen_r[diff_dn[SW-1:0]];

  // Window state consistency
  assign state_ok = started_r ? ((newest_r != '0) && seen_r[0])
                              : ((newest_r == '0) && (seen_r == '0));

  // Decide and form the next window
  always_comb begin
    started_nxt = 1'b1;
    newest_nxt  = newest_r;
    seen_nxt    = seen_r;
    accept      = 1'b1;
    if (!started_r) begin
      newest_nxt = seq;
      seen_nxt   = ONE;
    end else if (ahead) begin
      newest_nxt = seq;
      seen_nxt   = jump ? ONE : ((seen_r << diff_up[SW-1:0]) | ONE);
    end else begin
      accept   = !too_old && !seen_bit;
      seen_nxt = seen_r | (ONE << diff_dn[SW-1:0]);
    end
  end

  assign replay = !accept;

  // Advance the window only on an accepted envelope
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      newest_r  <= '0;
      seen_r    <= '0;
    end else if (take && accept) begin
      started_r <= started_nxt;
      newest_r  <= newest_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/envelope_acceptance_replay_check_unit.sv
// Top level: envelope acceptance and anti-replay check with register stages.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_valid / in_ready   | header fields, sequence, auth_ok
//  out_    | output    | out_valid / out_ready | status, payload type, sequence, relayed
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// A result passes through the input register, then the result register; one envelope per cycle while not stalled.
// The window compare, shift and update sit between the input and result registers.
// Synchronous active-low reset clears the window, configuration and valid flags.
// A stalled result holds; the input stage still accepts while the result stage frees.
`default_nettype none
module envelope_acceptance_replay_check_unit #(
  parameter int unsigned WINDOW_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_header_word0,
  input  logic [31:0] in_epoch,
  input  logic [63:0] in_source_id,
  input  logic [31:0] in_source_gen,
  input  logic [63:0] in_dest_id,
  input  logic [31:0] in_dest_gen,
  input  logic [63:0] in_via_id,
  input  logic [63:0] in_sequence_req,
  input  logic        in_auth_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_payload_type,
  output logic [63:0] out_sequence_out,
  output logic        out_relayed,
  input  logic        cfg_we,
  input  logic [eacr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_wdata
);
  import eacr_pkg::*;

  cfg_t    cfg_r;
  item_t   item_r;
  logic    in_full_r;
  logic    out_valid_r;
  status_t out_status_r;
  logic [7:0]  out_ptype_r;
  logic [63:0] out_seq_r;
  logic        out_relayed_r;

  logic    advance;
  logic    win_ok;
  logic    replay;
  logic    take;
  status_t chk_status;
  status_t fin_status;

  // Stage handshakes
  assign advance  = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOADED:     cfg_r.key_loaded          <= cfg_wdata[0];
        REG_EXP_EPOCH:      cfg_r.expected_epoch      <= cfg_wdata[31:0];
        REG_EXP_SOURCE:     cfg_r.expected_source     <= cfg_wdata;
        REG_EXP_SOURCE_GEN: cfg_r.expected_source_gen <= cfg_wdata[31:0];
        REG_EXP_DEST:       cfg_r.expected_dest       <= cfg_wdata;
        REG_EXP_DEST_GEN:   cfg_r.expected_dest_gen   <= cfg_wdata[31:0];
        REG_TYPE_LIMIT:     cfg_r.payload_type_limit  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the envelope until it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_ready) begin
      in_full_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{header_word0: in_header_word0, epoch: in_epoch,
                  source_id: in_source_id, source_gen: in_source_gen,
                  dest_id: in_dest_id, dest_gen: in_dest_gen,
                  via_id: in_via_id, sequence_req: in_sequence_req,
                  auth_ok: in_auth_ok};
    end
  end

  eacr_check u_check (
    .cfg        (cfg_r),
    .item       (item_r),
    .win_ok     (win_ok),
    .chk_status (chk_status)
  );

  assign take = advance && (chk_status == ST_OK);

  eacr_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .seq      (item_r.sequence_req),
    .replay   (replay),
    .state_ok (win_ok)
  );

  assign fin_status = ((chk_status == ST_OK) && replay) ? ST_REPLAY : chk_status;

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload, zeroed on any rejection
  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= fin_status;
      if (fin_status == ST_OK) begin
        out_ptype_r   <= item_r.header_word0[15:8];
        out_seq_r     <= item_r.sequence_req;
        out_relayed_r <= (item_r.via_id != '0);
      end else begin
        out_ptype_r   <= '0;
        out_seq_r     <= '0;
        out_relayed_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_payload_type = out_ptype_r;
  assign out_sequence_out = out_seq_r;
  assign out_relayed      = out_relayed_r;

endmodule
`default_nettype wire

// File: rtl/eacr_checker.sv
// Port-level checker for the envelope check unit, with its bind.
`default_nettype none
module eacr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [7:0]  out_payload_type,
  input wire logic [63:0] out_sequence_out,
  input wire logic        out_relayed
);
  import eacr_pkg::*;

  // A stalled result holds its status and sequence
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_sequence_out))
    else $error("result changed while stalled");

  // Rejected envelopes carry zeroed result fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_payload_type == 8'd0) && (out_sequence_out == 64'd0) && !out_relayed)
    else $error("rejection with nonzero fields");

  // An accepted envelope never has sequence zero
  a_ok_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> (out_sequence_out != 64'd0))
    else $error("accepted sequence zero");

  // Two back-to-back accepted transfers never repeat a sequence
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_status == ST_OK) && $past(rst_n) &&
    $past(out_valid && out_ready && (out_status == ST_OK)) |->
      (out_sequence_out != $past(out_sequence_out)))
    else $error("repeated sequence accepted");

endmodule

bind envelope_acceptance_replay_check_unit eacr_checker u_eacr_checker (.*);
`default_nettype wire

// File: sim/envelope_acceptance_replay_check_unit_test.sv
// Self-checking testbench for the envelope acceptance and replay check unit.
`timescale 1ns / 100ps
module envelope_acceptance_replay_check_unit_test;
  import eacr_pkg::*;

  localparam int unsigned REPLAY_WINDOW = 64;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned MAX_PRINTED   = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Header defects the stimulus can plant in an otherwise good envelope
  typedef enum int unsigned {
    FLAW_MAGIC, FLAW_VERSION, FLAW_FLAG, FLAW_TYPE, FLAW_RESERVED,
    FLAW_ZERO_EPOCH, FLAW_ZERO_SRC, FLAW_ZERO_SGEN, FLAW_ZERO_DST, FLAW_ZERO_DGEN,
    FLAW_ZERO_SEQ, FLAW_SAME_ENDS, FLAW_VIA_SRC, FLAW_VIA_DST, FLAW_FLAG_NO_VIA,
    FLAW_VIA_NO_FLAG, FLAW_EPOCH, FLAW_SOURCE, FLAW_DEST, FLAW_SGEN, FLAW_DGEN,
    FLAW_AUTH, FLAW_COUNT
  } flaw_t;

  typedef struct {
    status_t     status;
    logic [7:0]  ptype;
    logic [63:0] seq;
    logic        relayed;
  } verdict_t;

  // Receiver context and replay window copy; predicts and checks verdicts
  class verdict_ledger;
    logic        key_loaded;
    logic [31:0] exp_epoch;
    logic [63:0] exp_source;
    logic [31:0] exp_source_gen;
    logic [63:0] exp_dest;
    logic [31:0] exp_dest_gen;
    logic [7:0]  type_limit;
    bit          window_live;
    logic [63:0] newest_seq;
    logic [63:0] seen_bits;
    verdict_t    pending[$];
    int unsigned mismatches;
    int unsigned printed;

    function new();
      key_loaded     = 1'b0;
      exp_epoch      = '0;
      exp_source     = '0;
      exp_source_gen = '0;
      exp_dest       = '0;
      exp_dest_gen   = '0;
      type_limit     = '0;
      window_live    = 1'b0;
      newest_seq     = '0;
      seen_bits      = '0;
      mismatches     = 0;
      printed        = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
      case (idx)
        REG_KEY_LOADED:     key_loaded     = value[0];
        REG_EXP_EPOCH:      exp_epoch      = value[31:0];
        REG_EXP_SOURCE:     exp_source     = value;
        REG_EXP_SOURCE_GEN: exp_source_gen = value[31:0];
        REG_EXP_DEST:       exp_dest       = value;
        REG_EXP_DEST_GEN:   exp_dest_gen   = value[31:0];
        REG_TYPE_LIMIT:     type_limit     = value[7:0];
        default: ;
      endcase
    endfunction

    // Run the context, window state and header checks in priority order, replay check excluded
    function status_t screen(item_t it);
      logic [7:0] flag;
      logic [7:0] ptype;
      bit         window_sane;
      flag  = it.header_word0[23:16];
      ptype = it.header_word0[15:8];
      if (!key_loaded) return ST_INVALID;
      if (exp_epoch == 0 || exp_source == 0 || exp_source_gen == 0 || exp_dest == 0 ||
          exp_dest_gen == 0 || exp_source == exp_dest)
        return ST_INVALID;
      window_sane = window_live ? (newest_seq != 0 && seen_bits[0])
                                : (newest_seq == 0 && seen_bits == 0);
      if (!window_sane) return ST_INVALID;
      if (it.header_word0[63:32] != HDR_MAGIC || it.header_word0[31:24] != HDR_VERSION ||
          flag > 8'd1 || ptype > type_limit || it.header_word0[7:0] != 8'd0)
        return ST_INVALID;
      if (it.epoch == 0 || it.source_id == 0 || it.source_gen == 0 || it.dest_id == 0 ||
          it.dest_gen == 0 || it.source_id == it.dest_id || it.sequence_req == 0)
        return ST_INVALID;
      if (it.via_id != 0 && (it.via_id == it.source_id || it.via_id == it.dest_id))
        return ST_INVALID;
      if ((flag == 8'd0) != (it.via_id == 64'd0)) return ST_INVALID;
      if (it.epoch != exp_epoch) return ST_STALE_EP;
      if (it.source_id != exp_source) return ST_WRONG_SRC;
      if (it.dest_id != exp_dest) return ST_WRONG_DST;
      if (it.source_gen != exp_source_gen || it.dest_gen != exp_dest_gen) return ST_STALE_GEN;
      if (!it.auth_ok) return ST_AUTH_FAIL;
      return ST_OK;
    endfunction

    // Slide the window; return 0 for a repeated or too old sequence
    function bit slide_window(logic [63:0] seq);
      logic [63:0] delta;
      logic [63:0] span;
      span = {64{1'b1}} >> (64 - REPLAY_WINDOW);
      if (!window_live) begin
        window_live = 1'b1;
        newest_seq  = seq;
        seen_bits   = 64'd1;
        return 1'b1;
      end
      if (seq > newest_seq) begin
        delta = seq - newest_seq;
        if (delta >= REPLAY_WINDOW) seen_bits = 64'd1;
        else seen_bits = ((seen_bits << delta) | 64'd1) & span;
        newest_seq = seq;
        return 1'b1;
      end
      delta = newest_seq - seq;
      if (delta >= REPLAY_WINDOW) return 1'b0;
      if (seen_bits[delta[5:0]]) return 1'b0;
      seen_bits[delta[5:0]] = 1'b1;
      return 1'b1;
    endfunction

    function void admit_envelope(item_t it);
      verdict_t v;
      v.status = screen(it);
      if (v.status == ST_OK && !slide_window(it.sequence_req)) v.status = ST_REPLAY;
      if (v.status == ST_OK) begin
        v.ptype   = it.header_word0[15:8];
        v.seq     = it.sequence_req;
        v.relayed = (it.via_id != 0);
      end else begin
        v.ptype   = '0;
        v.seq     = '0;
        v.relayed = 1'b0;
      end
      pending.push_back(v);
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      if (printed < MAX_PRINTED) begin
        printed++;
        $display("[%0t] mismatch: %s", $time, what);
      end
    endfunction

    function void check_result(logic [2:0] status, logic [7:0] ptype, logic [63:0] seq,
                               logic relayed);
      verdict_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result status %0d with nothing pending", status));
        return;
      end
      want = pending.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
      if (ptype !== want.ptype)
        report_mismatch($sformatf("payload type %0h, predicted %0h", ptype, want.ptype));
      if (seq !== want.seq)
        report_mismatch($sformatf("sequence %0h, predicted %0h", seq, want.seq));
      if (relayed !== want.relayed)
        report_mismatch($sformatf("relayed %0b, predicted %0b", relayed, want.relayed));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_header_word0;
  logic [31:0] in_epoch;
  logic [63:0] in_source_id;
  logic [31:0] in_source_gen;
  logic [63:0] in_dest_id;
  logic [31:0] in_dest_gen;
  logic [63:0] in_via_id;
  logic [63:0] in_sequence_req;
  logic        in_auth_ok;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_payload_type;
  logic [63:0] out_sequence_out;
  logic        out_relayed;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_wdata;

  verdict_ledger ledger;

  // Context the stimulus aims at, mirrored from the last register writes
  logic [31:0] ctx_epoch;
  logic [63:0] ctx_src;
  logic [31:0] ctx_sgen;
  logic [63:0] ctx_dst;
  logic [31:0] ctx_dgen;
  logic [7:0]  ctx_limit;
  logic [63:0] seq_cursor;

  int unsigned in_sent;
  bit          in_burst;
  bit          hold_off_request;
  int unsigned idle_cycles;

  envelope_acceptance_replay_check_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_header_word0  (in_header_word0),
    .in_epoch         (in_epoch),
    .in_source_id     (in_source_id),
    .in_source_gen    (in_source_gen),
    .in_dest_id       (in_dest_id),
    .in_dest_gen      (in_dest_gen),
    .in_via_id        (in_via_id),
    .in_sequence_req  (in_sequence_req),
    .in_auth_ok       (in_auth_ok),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_payload_type (out_payload_type),
    .out_sequence_out (out_sequence_out),
    .out_relayed      (out_relayed),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Advance the cursor slowly with rare jumps; pick near it, ahead or behind with equal odds
  function automatic logic [63:0] pick_sequence();
    if ($urandom_range(0, 99) < 3) seq_cursor = seq_cursor + $urandom_range(64, 5000);
    else seq_cursor = seq_cursor + $urandom_range(0, 2);
    if ($urandom_range(0, 1) == 0) return seq_cursor + $urandom_range(0, 8);
    return seq_cursor - $urandom_range(0, 70);
  endfunction

  function automatic item_t well_formed(logic [63:0] seq, bit relay);
    item_t it;
    it.via_id       = relay ? (rand64() | 64'd1) : 64'd0;
    it.header_word0 = {HDR_MAGIC, HDR_VERSION, 7'd0, relay,
                       8'($urandom_range(0, int'(ctx_limit))), 8'd0};
    it.epoch        = ctx_epoch;
    it.source_id    = ctx_src;
    it.source_gen   = ctx_sgen;
    it.dest_id      = ctx_dst;
    it.dest_gen     = ctx_dgen;
    it.sequence_req = seq;
    it.auth_ok      = 1'b1;
    return it;
  endfunction

  function automatic item_t apply_flaw(item_t it, flaw_t flaw);
    item_t bad;
    bad = it;
    case (flaw)
      FLAW_MAGIC:
        bad.header_word0 = bad.header_word0 ^ (64'd1 << (32 + $urandom_range(0, 31)));
      FLAW_VERSION:     bad.header_word0[31:24] = HDR_VERSION ^ 8'($urandom_range(1, 255));
      FLAW_FLAG:        bad.header_word0[23:16] = 8'($urandom_range(2, 255));
      FLAW_TYPE: begin
        if (ctx_limit != 8'hFF)
          bad.header_word0[15:8] = 8'($urandom_range(int'(ctx_limit) + 1, 255));
      end
      FLAW_RESERVED:    bad.header_word0[7:0] = 8'($urandom_range(1, 255));
      FLAW_ZERO_EPOCH:  bad.epoch = '0;
      FLAW_ZERO_SRC:    bad.source_id = '0;
      FLAW_ZERO_SGEN:   bad.source_gen = '0;
      FLAW_ZERO_DST:    bad.dest_id = '0;
      FLAW_ZERO_DGEN:   bad.dest_gen = '0;
      FLAW_ZERO_SEQ:    bad.sequence_req = '0;
      FLAW_SAME_ENDS:   bad.dest_id = bad.source_id;
      FLAW_VIA_SRC: begin
        bad.via_id = bad.source_id;
        bad.header_word0[23:16] = 8'd1;
      end
      FLAW_VIA_DST: begin
        bad.via_id = bad.dest_id;
        bad.header_word0[23:16] = 8'd1;
      end
      FLAW_FLAG_NO_VIA: begin
        bad.via_id = '0;
        bad.header_word0[23:16] = 8'd1;
      end
      FLAW_VIA_NO_FLAG: begin
        bad.via_id = rand64() | 64'd1;
        bad.header_word0[23:16] = 8'd0;
      end
      FLAW_EPOCH:  bad.epoch = bad.epoch ^ (32'd1 << $urandom_range(0, 31));
      FLAW_SOURCE: bad.source_id = bad.source_id ^ (64'd1 << $urandom_range(0, 63));
      FLAW_DEST:   bad.dest_id = bad.dest_id ^ (64'd1 << $urandom_range(0, 63));
      FLAW_SGEN:   bad.source_gen = bad.source_gen ^ (32'd1 << $urandom_range(0, 31));
      FLAW_DGEN:   bad.dest_gen = bad.dest_gen ^ (32'd1 << $urandom_range(0, 31));
      FLAW_AUTH:   bad.auth_ok = 1'b0;
      default: ;
    endcase
    return bad;
  endfunction

  // Offer one envelope after a drawn gap and hold it until the transfer
  task automatic send_envelope(input item_t it);
    int unsigned gap;
    if (in_sent % 32 == 0) in_burst = ($urandom_range(0, 3) == 0);
    gap = in_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_header_word0 <= it.header_word0;
    in_epoch        <= it.epoch;
    in_source_id    <= it.source_id;
    in_source_gen   <= it.source_gen;
    in_dest_id      <= it.dest_id;
    in_dest_gen     <= it.dest_gen;
    in_via_id       <= it.via_id;
    in_sequence_req <= it.sequence_req;
    in_auth_ok      <= it.auth_ok;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    ledger.admit_envelope(it);
    in_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.write_register(idx, value);
  endtask

  // Drain the block, then rewrite the whole context and the spare index
  task automatic set_context(input bit key, input logic [31:0] ep, input logic [63:0] src,
                             input logic [31:0] sg, input logic [63:0] dst,
                             input logic [31:0] dg, input logic [7:0] lim);
    release_input();
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    set_register(REG_KEY_LOADED, {$urandom(), $urandom() & 32'hFFFF_FFFE} | 64'(key));
    set_register(REG_EXP_EPOCH, {$urandom(), ep});
    set_register(REG_EXP_SOURCE, src);
    set_register(REG_EXP_SOURCE_GEN, {$urandom(), sg});
    set_register(REG_EXP_DEST, dst);
    set_register(REG_EXP_DEST_GEN, {$urandom(), dg});
    set_register(REG_TYPE_LIMIT, {$urandom(), 24'($urandom()), lim});
    set_register(REG_SPARE, rand64());
    @(negedge clk);
    cfg_we <= 1'b0;
    ctx_epoch = ep;
    ctx_src   = src;
    ctx_sgen  = sg;
    ctx_dst   = dst;
    ctx_dgen  = dg;
    ctx_limit = lim;
  endtask

  task automatic random_context(input logic [7:0] lim);
    set_context(1'b1, $urandom() | 32'd1, rand64() | 64'd1, $urandom() | 32'd1,
                rand64() | 64'd2, $urandom() | 32'd1, lim);
  endtask

  // Mostly good envelopes with random content, some flawed, some pure noise
  task automatic run_random(input int unsigned count);
    int unsigned n;
    int unsigned r;
    item_t it;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        it = well_formed(pick_sequence(), $urandom_range(0, 2) == 0);
        if ($urandom_range(0, 19) == 0) it.auth_ok = 1'b0;
      end else if (r < 90) begin
        it = apply_flaw(well_formed(pick_sequence(), $urandom_range(0, 2) == 0),
                        flaw_t'($urandom_range(0, FLAW_COUNT - 1)));
      end else begin
        it.header_word0 = rand64();
        it.epoch        = $urandom();
        it.source_id    = rand64();
        it.source_gen   = $urandom();
        it.dest_id      = rand64();
        it.dest_gen     = $urandom();
        it.via_id       = rand64();
        it.sequence_req = rand64();
        it.auth_ok      = 1'($urandom_range(0, 1));
      end
      send_envelope(it);
    end
  endtask

  // Result sink: drawn stalls, bursts without stalls, one long hold on request
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    bit          burst;
    taken = 0;
    burst = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 13);
      if (hold_off_request) begin
        gap = LONG_HOLD;
        hold_off_request = 1'b0;
      end
      @(negedge clk);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      ledger.check_result(out_status, out_payload_type, out_sequence_out, out_relayed);
      taken++;
    end
  end

  // Abort when no transfer happens on either channel for too long
  always @(posedge clk) begin : stall_watch
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int f;
    int unsigned k;
    int unsigned z;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_header_word0  = '0;
    in_epoch         = '0;
    in_source_id     = '0;
    in_source_gen    = '0;
    in_dest_id       = '0;
    in_dest_gen      = '0;
    in_via_id        = '0;
    in_sequence_req  = '0;
    in_auth_ok       = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    ctx_epoch        = '0;
    ctx_src          = '0;
    ctx_sgen         = '0;
    ctx_dst          = '0;
    ctx_dgen         = '0;
    ctx_limit        = '0;
    seq_cursor       = 64'd1000;
    in_sent          = 0;
    in_burst         = 1'b0;
    hold_off_request = 1'b0;
    ledger = new();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // No key after reset: invalid
    send_envelope(well_formed(64'd5, 1'b0));
    // Key loaded but the expected context still zero: invalid
    set_context(1'b1, '0, '0, '0, '0, '0, '0);
    send_envelope(well_formed(64'd6, 1'b0));

    // Window corner cases, then every header defect once
    set_context(1'b1, 32'd1, 64'd1, 32'hFFFF_FFFF, {64{1'b1}}, 32'd1, 8'd200);
    send_envelope(well_formed(64'd100, 1'b0));
    send_envelope(well_formed(64'd100, 1'b0));
    send_envelope(well_formed(64'd99, 1'b1));
    send_envelope(well_formed(64'd37, 1'b0));
    send_envelope(well_formed(64'd36, 1'b0));
    send_envelope(well_formed(64'd300, 1'b0));
    send_envelope(well_formed(64'd299, 1'b1));
    for (f = 0; f < FLAW_COUNT; f++)
      send_envelope(apply_flaw(well_formed(64'd400 + f, 1'b0), flaw_t'(f)));

    random_context(8'($urandom_range(0, 255)));
    run_random(300);

    // Extreme context values with the tightest type limit
    set_context(1'b1, 32'hFFFF_FFFF, {64{1'b1}}, 32'd1, 64'd1, 32'hFFFF_FFFF, 8'd0);
    run_random(200);

    // Each broken expected context in turn
    for (z = 0; z < 5; z++) begin
      set_context(1'b1, (z == 0) ? 32'd0 : ($urandom() | 32'd1),
                  (z == 1) ? 64'd0 : (rand64() | 64'd1),
                  (z == 2) ? 32'd0 : ($urandom() | 32'd1),
                  (z == 3) ? 64'd0 : (rand64() | 64'd2),
                  (z == 4) ? 32'd0 : ($urandom() | 32'd1), 8'hFF);
      run_random(20);
    end
    set_context(1'b1, 32'h1234_5678, 64'hA5A5_0000_0000_5A5A, 32'd7,
                64'hA5A5_0000_0000_5A5A, 32'd9, 8'hFF);
    run_random(30);
    set_context(1'b0, $urandom() | 32'd1, rand64() | 64'd1, $urandom() | 32'd1,
                rand64() | 64'd2, $urandom() | 32'd1, 8'hFF);
    run_random(30);

    // Long receiver hold while envelopes keep coming
    random_context(8'hFF);
    hold_off_request = 1'b1;
    run_random(350);

    // Sequences at the top of the range
    random_context(8'($urandom_range(0, 255)));
    seq_cursor = 64'hFFFF_FFFF_FFFF_FF00 - 64'd300;
    run_random(150);
    send_envelope(well_formed({64{1'b1}}, 1'b1));

    release_input();
    for (k = 0; k < DRAIN_LIMIT && ledger.pending.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ledger.pending.size() != 0)
      ledger.report_mismatch($sformatf("%0d results never arrived", ledger.pending.size()));
    if (ledger.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
